FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the bmh_checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is active.
`define BMH_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is active.
`define BMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bmh_pkg.sv
package bmh_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 16;

  localparam int KEY_W    = 32;
  localparam int ID_W     = 16;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REPLACE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHK,
    S_UP_CMP,
    S_REP_CMP,
    S_DN_CHK,
    S_DN_LEFT,
    S_DN_CMP,
    S_RD_CAP,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_ROOT,
    RD_LEFT,
    RD_RIGHT,
    RD_SLOT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CAND,
    WR_PARENT,
    WR_CHILD
  } wr_sel_t;

  typedef struct packed {
    logic    capture;
    logic    ins_start;
    logic    clear;
    logic    set_pos_root;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    latch_left;
    logic    latch_slot;
    logic    set_full;
    logic    set_bad;
    logic    set_acc;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_root;
    logic parent_gt;
    logic rep_ok;
    logic child_oob;
    logic right_oob;
    logic stop_down;
    logic slot_ok;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/bmh_if.sv
interface bmh_in_if;
  logic                          valid;
  logic                          ready;
  logic [bmh_pkg::OP_W-1:0]      operation;
  logic [bmh_pkg::KEY_W-1:0]     key;
  logic [bmh_pkg::ID_W-1:0]      item_id;
  logic [bmh_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, output operation, output key, output item_id,
                  output slot, input ready);
  modport sink (input valid, input operation, input key, input item_id,
                input slot, output ready);
endinterface

interface bmh_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmh_pkg::STATUS_W-1:0]  status;
  logic                          accepted;
  logic [bmh_pkg::COUNT_W-1:0]   count;
  logic [bmh_pkg::KEY_W-1:0]     top_key;
  logic [bmh_pkg::ID_W-1:0]      top_id;
  logic [bmh_pkg::KEY_W-1:0]     slot_key;
  logic [bmh_pkg::ID_W-1:0]      slot_id;

  modport source (output valid, output status, output accepted, output count,
                  output top_key, output top_id, output slot_key,
                  output slot_id, input ready);
  modport sink (input valid, input status, input accepted, input count,
                input top_key, input top_id, input slot_key, input slot_id,
                output ready);
endinterface

FILE: rtl/core/bmh_ctrl.sv
module bmh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bmh_pkg::stat_t stat,
  output bmh_pkg::cmd_t  cmd
);

  bmh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.rd_sel       = bmh_pkg::RD_NONE;
    cmd.wr_sel       = bmh_pkg::WR_NONE;
    in_ready         = 1'b0;
    unique case (state_r)
      bmh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bmh_pkg::S_DISPATCH;
        end
      end
      bmh_pkg::S_DISPATCH: begin
        unique case (stat.op)
          bmh_pkg::OP_INSERT: begin
            if (stat.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = bmh_pkg::S_FIN_RD;
            end else begin
              cmd.ins_start = 1'b1;
              cmd.set_acc   = 1'b1;
              state_nxt     = bmh_pkg::S_UP_CHK;
            end
          end
          bmh_pkg::OP_REPLACE: begin
            cmd.rd_sel = bmh_pkg::RD_ROOT;
            state_nxt  = bmh_pkg::S_REP_CMP;
          end
          bmh_pkg::OP_READ: begin
            if (stat.slot_ok) begin
              cmd.rd_sel = bmh_pkg::RD_SLOT;
              state_nxt  = bmh_pkg::S_RD_CAP;
            end else begin
              cmd.set_bad = 1'b1;
              state_nxt   = bmh_pkg::S_FIN_RD;
            end
          end
          bmh_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = bmh_pkg::S_FIN_RD;
          end
          default: state_nxt = bmh_pkg::S_FIN_RD;
        endcase
      end
      bmh_pkg::S_UP_CHK: begin
        if (stat.pos_root) begin
          cmd.wr_sel = bmh_pkg::WR_CAND;
          state_nxt  = bmh_pkg::S_FIN_RD;
        end else begin
          cmd.rd_sel = bmh_pkg::RD_PARENT;
          state_nxt  = bmh_pkg::S_UP_CMP;
        end
      end
      bmh_pkg::S_UP_CMP: begin
        if (stat.parent_gt) begin
          cmd.wr_sel = bmh_pkg::WR_CAND;
          state_nxt  = bmh_pkg::S_FIN_RD;
        end else begin
          cmd.wr_sel = bmh_pkg::WR_PARENT;
          state_nxt  = bmh_pkg::S_UP_CHK;
        end
      end
      bmh_pkg::S_REP_CMP: begin
        if (!stat.empty && stat.rep_ok) begin
          cmd.set_acc      = 1'b1;
          cmd.set_pos_root = 1'b1;
          state_nxt        = bmh_pkg::S_DN_CHK;
        end else begin
          state_nxt = bmh_pkg::S_FIN_RD;
        end
      end
      bmh_pkg::S_DN_CHK: begin
        if (stat.child_oob) begin
          cmd.wr_sel = bmh_pkg::WR_CAND;
          state_nxt  = bmh_pkg::S_FIN_RD;
        end else begin
          cmd.rd_sel = bmh_pkg::RD_LEFT;
          state_nxt  = bmh_pkg::S_DN_LEFT;
        end
      end
      bmh_pkg::S_DN_LEFT: begin
        cmd.latch_left = 1'b1;
        if (!stat.right_oob) begin
          cmd.rd_sel = bmh_pkg::RD_RIGHT;
        end
        state_nxt = bmh_pkg::S_DN_CMP;
      end
      bmh_pkg::S_DN_CMP: begin
        if (stat.stop_down) begin
          cmd.wr_sel = bmh_pkg::WR_CAND;
          state_nxt  = bmh_pkg::S_FIN_RD;
        end else begin
          cmd.wr_sel = bmh_pkg::WR_CHILD;
          state_nxt  = bmh_pkg::S_DN_CHK;
        end
      end
      bmh_pkg::S_RD_CAP: begin
        cmd.latch_slot = 1'b1;
        state_nxt      = bmh_pkg::S_FIN_RD;
      end
      bmh_pkg::S_FIN_RD: begin
        cmd.rd_sel = bmh_pkg::RD_ROOT;
        state_nxt  = bmh_pkg::S_FIN_OUT;
      end
      bmh_pkg::S_FIN_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = bmh_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmh_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/bmh_dpath.sv
module bmh_dpath #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = bmh_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmh_pkg::cmd_t                 cmd,
  output bmh_pkg::stat_t                stat,
  input  logic [bmh_pkg::OP_W-1:0]      in_operation,
  input  logic [bmh_pkg::KEY_W-1:0]     in_key,
  input  logic [bmh_pkg::ID_W-1:0]      in_item_id,
  input  logic [bmh_pkg::SLOT_W-1:0]    in_slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmh_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_accepted,
  output logic [bmh_pkg::COUNT_W-1:0]   out_count,
  output logic [bmh_pkg::KEY_W-1:0]     out_top_key,
  output logic [bmh_pkg::ID_W-1:0]      out_top_id,
  output logic [bmh_pkg::KEY_W-1:0]     out_slot_key,
  output logic [bmh_pkg::ID_W-1:0]      out_slot_id
);

  localparam int KW  = bmh_pkg::KEY_W;
  localparam int IDW = (ID_BITS < bmh_pkg::ID_W) ? ID_BITS : bmh_pkg::ID_W;
  localparam int EW  = KW + IDW;
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CIW = AW + 2;
  localparam int SCW = (CW > bmh_pkg::SLOT_W) ? CW : bmh_pkg::SLOT_W;

  // Heap storage: key in the upper bits, id in the lower bits.
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_r;

  bmh_pkg::op_t           op_r;
  logic [KW-1:0]          cand_key_r;
  logic [IDW-1:0]         cand_id_r;
  logic [bmh_pkg::SLOT_W-1:0] slot_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [EW-1:0]          left_r;
  bmh_pkg::status_t       res_status_r;
  logic                   res_acc_r;
  logic [EW-1:0]          res_slot_r;
  logic                   out_valid_r, out_valid_nxt;

  logic [KW-1:0]  rd_key;
  logic [CIW-1:0] child_idx, right_idx, chosen_idx, count_ext;
  logic [AW-1:0]  parent_idx;
  logic           go_right;
  logic [EW-1:0]  chosen;
  logic [AW-1:0]  rd_addr;
  logic [EW-1:0]  wr_data;

  assign rd_key     = rd_data_r[EW-1:IDW];
  assign count_ext  = CIW'(count_r);
  assign child_idx  = (CIW'(pos_r) << 1) | CIW'(1);
  assign right_idx  = child_idx + CIW'(1);
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  assign go_right   = (right_idx < count_ext) && (left_r[EW-1:IDW] < rd_key);
  assign chosen     = go_right ? rd_data_r : left_r;
  assign chosen_idx = go_right ? right_idx : child_idx;

  always_comb begin
    stat.op        = op_r;
    stat.full      = (count_r == CW'(CAPACITY));
    stat.empty     = (count_r == '0);
    stat.pos_root  = (pos_r == '0);
    stat.parent_gt = (rd_key > cand_key_r);
    stat.rep_ok    = (cand_key_r < rd_key);
    stat.child_oob = (child_idx >= count_ext);
    stat.right_oob = (right_idx >= count_ext);
    stat.stop_down = (cand_key_r >= chosen[EW-1:IDW]);
    stat.slot_ok   = (SCW'(slot_r) < SCW'(count_r));
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      bmh_pkg::RD_PARENT: rd_addr = parent_idx;
      bmh_pkg::RD_LEFT:   rd_addr = AW'(child_idx);
      bmh_pkg::RD_RIGHT:  rd_addr = AW'(right_idx);
      bmh_pkg::RD_SLOT:   rd_addr = AW'(slot_r);
      default:            rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      bmh_pkg::WR_PARENT: wr_data = rd_data_r;
      bmh_pkg::WR_CHILD:  wr_data = chosen;
      default:            wr_data = {cand_key_r, cand_id_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sel != bmh_pkg::WR_NONE) begin
      mem[pos_r] <= wr_data;
    end
    if (cmd.rd_sel != bmh_pkg::RD_NONE) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.ins_start) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.ins_start) begin
      pos_nxt = AW'(count_r);
    end else if (cmd.set_pos_root) begin
      pos_nxt = '0;
    end else if (cmd.wr_sel == bmh_pkg::WR_PARENT) begin
      pos_nxt = parent_idx;
    end else if (cmd.wr_sel == bmh_pkg::WR_CHILD) begin
      pos_nxt = AW'(chosen_idx);
    end
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.capture) begin
      op_r         <= bmh_pkg::op_t'(in_operation);
      cand_key_r   <= in_key;
      cand_id_r    <= in_item_id[IDW-1:0];
      slot_r       <= in_slot;
      res_status_r <= bmh_pkg::ST_OK;
      res_acc_r    <= 1'b0;
      res_slot_r   <= '0;
    end
    if (cmd.latch_left) begin
      left_r <= rd_data_r;
    end
    if (cmd.latch_slot) begin
      res_slot_r <= rd_data_r;
    end
    if (cmd.set_full) begin
      res_status_r <= bmh_pkg::ST_FULL;
    end
    if (cmd.set_bad) begin
      res_status_r <= bmh_pkg::ST_BAD_SLOT;
    end
    if (cmd.set_acc) begin
      res_acc_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_status   <= res_status_r;
      out_accepted <= res_acc_r;
      out_count    <= bmh_pkg::COUNT_W'(count_r);
      out_top_key  <= (count_r != '0) ? rd_key : '0;
      out_top_id   <= (count_r != '0) ? bmh_pkg::ID_W'(rd_data_r[IDW-1:0]) : '0;
      out_slot_key <= res_slot_r[EW-1:IDW];
      out_slot_id  <= bmh_pkg::ID_W'(res_slot_r[IDW-1:0]);
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/bounded_max_heap_k_smallest_core.sv
// Channel | Direction | Handshake     | Payload
// in_ch   | sink      | valid / ready | operation, key, item_id, slot
// out_ch  | source    | valid / ready | status, accepted, count, top_key, top_id,
//         |           |               | slot_key, slot_id
//
// One transaction at a time, one result each. An entry moves at most floor(log2(CAPACITY))
// levels: an insert sifts it up from the next free slot until a parent stops it or it
// reaches the root, an accepted replace sifts it down from the root until a child stops it
// or it reaches a leaf. Rejected replace, read, bad read, clear and full insert move none.
// rst_n is synchronous and active low; it empties the heap and drops any result.
// A stalled result waits in the output register while the next transaction is taken.

module bounded_max_heap_k_smallest_core #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = bmh_pkg::ID_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  bmh_in_if.sink   in_ch,
  bmh_out_if.source out_ch
);

  // The controller sequences sift-up and sift-down walks; the datapath owns
  // the heap memory, the entry count and the result register.
  bmh_pkg::cmd_t  cmd;
  bmh_pkg::stat_t stat;

  bmh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmh_dpath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .in_item_id   (in_ch.item_id),
    .in_slot      (in_ch.slot),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_accepted (out_ch.accepted),
    .out_count    (out_ch.count),
    .out_top_key  (out_ch.top_key),
    .out_top_id   (out_ch.top_id),
    .out_slot_key (out_ch.slot_key),
    .out_slot_id  (out_ch.slot_id)
  );

endmodule

FILE: rtl/core/bmh_checker.sv
`include "assert_macros.svh"

module bmh_checker #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmh_pkg::STATUS_W-1:0]  out_status,
  input logic                          out_accepted,
  input logic [bmh_pkg::COUNT_W-1:0]   out_count,
  input logic [bmh_pkg::KEY_W-1:0]     out_top_key,
  input logic [bmh_pkg::ID_W-1:0]      out_top_id,
  input logic [bmh_pkg::KEY_W-1:0]     out_slot_key,
  input logic [bmh_pkg::ID_W-1:0]      out_slot_id
);

  `BMH_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_top_key), "result dropped or changed while stalled")
  `BMH_ASSERT_RST(a_full_count, clk, rst_n, out_valid && out_status == bmh_pkg::ST_FULL |-> !out_accepted && out_count == bmh_pkg::COUNT_W'(CAPACITY), "full status without a full heap")
  `BMH_ASSERT_RST(a_empty_top, clk, rst_n, out_valid && out_count == '0 |-> out_top_key == '0 && out_top_id == '0, "empty heap shows a root")
  `BMH_ASSERT_RST(a_bad_slot, clk, rst_n, out_valid && out_status == bmh_pkg::ST_BAD_SLOT |-> out_slot_key == '0 && out_slot_id == '0 && !out_accepted, "bad slot read returns data")
  `BMH_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind bounded_max_heap_k_smallest_core bmh_checker #(.CAPACITY(CAPACITY)) u_bmh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_accepted (out_ch.accepted),
  .out_count    (out_ch.count),
  .out_top_key  (out_ch.top_key),
  .out_top_id   (out_ch.top_id),
  .out_slot_key (out_ch.slot_key),
  .out_slot_id  (out_ch.slot_id)
);

FILE: verif/bmh_heap_checker.sv
module bmh_heap_checker (
  input  logic clk,
  input  logic rst_n,
  bmh_in_if    in_mon,
  bmh_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bmh_pkg::*;

  localparam int HEAP_DEPTH = CAPACITY_DEF;

  typedef struct packed {
    status_t              status;
    logic                 accepted;
    logic [COUNT_W-1:0]   count;
    logic [KEY_W-1:0]     top_key;
    logic [ID_W-1:0]      top_id;
    logic [KEY_W-1:0]     slot_key;
    logic [ID_W-1:0]      slot_id;
  } heap_result_t;

  // Shadow copy of the heap contents and fill level.
  logic [KEY_W-1:0] shadow_keys [HEAP_DEPTH];
  logic [ID_W-1:0]  shadow_ids  [HEAP_DEPTH];
  int               shadow_fill;

  heap_result_t pending_heap_results[$];
  heap_result_t want;
  int           mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    shadow_fill = 0;
  end

  task automatic flag_mismatch(string what, logic [KEY_W-1:0] exp_val,
                               logic [KEY_W-1:0] got_val);
    $display("mismatch: %s expected %0h got %0h", what, exp_val, got_val);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [KEY_W-1:0] exp_val,
                             logic [KEY_W-1:0] got_val);
    if (exp_val !== got_val) flag_mismatch(what, exp_val, got_val);
  endtask

  function automatic heap_result_t apply_heap_op(op_t op, logic [KEY_W-1:0] key,
                                                 logic [ID_W-1:0] id,
                                                 logic [SLOT_W-1:0] slot);
    heap_result_t r;
    int pos;
    int parent;
    int child;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_fill >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = shadow_fill;
          shadow_fill++;
          // Move up past every parent whose key is not larger.
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (shadow_keys[parent] > key) break;
            shadow_keys[pos] = shadow_keys[parent];
            shadow_ids[pos]  = shadow_ids[parent];
            pos = parent;
          end
          shadow_keys[pos] = key;
          shadow_ids[pos]  = id;
          r.accepted = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (shadow_fill > 0 && key < shadow_keys[0]) begin
          pos = 0;
          while (1) begin
            child = 2 * pos + 1;
            if (child >= shadow_fill) break;
            // The left child wins a tie.
            if (child + 1 < shadow_fill && shadow_keys[child] < shadow_keys[child + 1])
              child++;
            if (key >= shadow_keys[child]) break;
            shadow_keys[pos] = shadow_keys[child];
            shadow_ids[pos]  = shadow_ids[child];
            pos = child;
          end
          shadow_keys[pos] = key;
          shadow_ids[pos]  = id;
          r.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(slot) < shadow_fill) begin
          r.slot_key = shadow_keys[slot];
          r.slot_id  = shadow_ids[slot];
        end else begin
          r.status = ST_BAD_SLOT;
        end
      end
      OP_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    if (shadow_fill > 0) begin
      r.top_key = shadow_keys[0];
      r.top_id  = shadow_ids[0];
    end
    return r;
  endfunction

  // Results are checked before the input of the same edge is predicted, since
  // a result leaving at an edge always belongs to an earlier transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      pending_heap_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_heap_results.size() == 0) begin
          flag_mismatch("result with no transaction pending", '0, out_mon.top_key);
        end else begin
          want = pending_heap_results.pop_front();
          check_field("status",   KEY_W'(want.status),   KEY_W'(out_mon.status));
          check_field("accepted", KEY_W'(want.accepted), KEY_W'(out_mon.accepted));
          check_field("count",    KEY_W'(want.count),    KEY_W'(out_mon.count));
          check_field("top_key",  want.top_key,          out_mon.top_key);
          check_field("top_id",   KEY_W'(want.top_id),   KEY_W'(out_mon.top_id));
          check_field("slot_key", want.slot_key,         out_mon.slot_key);
          check_field("slot_id",  KEY_W'(want.slot_id),  KEY_W'(out_mon.slot_id));
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_heap_results.push_back(apply_heap_op(op_t'(in_mon.operation),
                                                     in_mon.key, in_mon.item_id,
                                                     in_mon.slot));
    end
    fail_count  <= mismatches;
    outstanding <= pending_heap_results.size();
  end

endmodule

FILE: verif/bounded_max_heap_k_smallest_core_test.sv
module bounded_max_heap_k_smallest_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmh_pkg::*;

  // The slowest correct run is well below this: about 1400 transactions, each
  // with a long sender gap, a long receiver stall and a replace walking the full depth.
  localparam int CYCLE_LIMIT  = 600000;
  // Longest operation is a replace walking four levels.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 340;
  // A clear starts each run of random transactions so the heap fills and
  // drains over and over.
  localparam int RUN_LENGTH    = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;
  int fail_count;
  int outstanding;

  bmh_in_if  in_ch();
  bmh_out_if out_ch();

  bounded_max_heap_k_smallest_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmh_heap_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides each cycle whether to take a result.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_max_heap_k_smallest_core_test: done, errors");
      $finish;
    end
  end

  // Presents one transaction after a random number of idle cycles and returns
  // in the time step of the edge at which it was accepted. Valid is written
  // exactly once per time step, so back-to-back transactions keep it high.
  task automatic send(op_t op, logic [KEY_W-1:0] key, logic [ID_W-1:0] id,
                      logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= key;
    in_ch.item_id   <= id;
    in_ch.slot      <= slot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drops valid and holds off until every expected result has come out. The
  // first edge lets the checker count the transaction accepted just before.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random traffic. Inserts are the most frequent operation, so in each run the heap reaches
  // full and rejects inserts; replaces then mostly land on a full heap.
  task automatic run_random_phase(int items, int idle, int stall);
    op_t              op;
    logic [KEY_W-1:0] key;
    int               pick;
    idle_pct  = idle;
    stall_pct <= stall;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (n % RUN_LENGTH == 0 || pick < 1) op = OP_CLEAR;
      else if (pick < 43)                  op = OP_INSERT;
      else if (pick < 71)                  op = OP_REPLACE;
      else                                 op = OP_READ;
      // Narrow key ranges give plenty of equal keys for the tie rules.
      case ($urandom_range(5))
        0, 1:    key = $urandom();
        2:       key = $urandom_range(15);
        3:       key = 32'hFFFF_FFFF - $urandom_range(3);
        4:       key = $urandom_range(3);
        default: key = $urandom() >> $urandom_range(31);
      endcase
      send(op, key, ID_W'($urandom_range(16'hFFFF)), SLOT_W'($urandom_range(15)));
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.key       = '0;
    in_ch.item_id   = '0;
    in_ch.slot      = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions with no idling on either side.
    // Operations on an empty heap: bad read, rejected replace, clear.
    send(OP_READ,    32'd0,         16'h0000, 4'd0);
    send(OP_REPLACE, 32'd5,         16'h0001, 4'd0);
    send(OP_CLEAR,   32'd0,         16'h0000, 4'd0);
    // Extreme keys and ids; an equal key climbs past its parent.
    send(OP_INSERT,  32'hFFFF_FFFF, 16'hFFFF, 4'd0);
    send(OP_INSERT,  32'd0,         16'h0000, 4'd0);
    send(OP_INSERT,  32'hFFFF_FFFF, 16'h1234, 4'd0);
    // A replace equal to the root is rejected; one just below it sifts down.
    send(OP_REPLACE, 32'hFFFF_FFFF, 16'h5555, 4'd0);
    send(OP_REPLACE, 32'hFFFF_FFFE, 16'hABCD, 4'd0);
    send(OP_READ,    32'd0,         16'h0000, 4'd1);
    send(OP_READ,    32'd0,         16'h0000, 4'd2);
    // Reads at and past the fill level, the last slot among them.
    send(OP_READ,    32'd0,         16'h0000, 4'd3);
    send(OP_READ,    32'hFFFF_FFFF, 16'hFFFF, 4'd15);
    send(OP_CLEAR,   32'd0,         16'h0000, 4'd0);
    // Equal children: the sift down must take the left one.
    send(OP_INSERT,  32'd20,        16'h0001, 4'd0);
    send(OP_INSERT,  32'd20,        16'h0002, 4'd0);
    send(OP_INSERT,  32'd20,        16'h0003, 4'd0);
    send(OP_REPLACE, 32'd5,         16'h0004, 4'd0);
    send(OP_READ,    32'd0,         16'h0000, 4'd1);
    send(OP_READ,    32'd0,         16'h0000, 4'd2);
    // A larger candidate is rejected.
    send(OP_REPLACE, 32'd30,        16'h0005, 4'd0);
    wait_drained();

    // Random phases; each ends by holding off until all results are back.
    run_random_phase(PHASE_ITEMS, 0,  0);
    run_random_phase(PHASE_ITEMS, 81, 0);
    run_random_phase(PHASE_ITEMS, 0,  81);
    run_random_phase(PHASE_ITEMS, 13, 13);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_max_heap_k_smallest_core_test: done, clean");
    end else begin
      $display("bounded_max_heap_k_smallest_core_test: done, errors");
    end
    $finish;
  end

endmodule
